>>> rtl/arp_resolver_single_entry_defines.svh
// Assertion macros shared by the checker files of the ARP resolver.
// Each macro expects signals named clk and rst_n in the scope that uses it.
`ifndef ARP_RESOLVER_SINGLE_ENTRY_DEFINES_SVH
`define ARP_RESOLVER_SINGLE_ENTRY_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ARPRES_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ARPRES_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/arpres_pkg.sv
// Package for the ARP resolver: operation and result codes, frame constants,
// register indexes and the receive status type. Depends on nothing.
package arpres_pkg;

    localparam int TIMER_WIDTH = 24;
    localparam int MAC_W       = 48;
    localparam int IP_W        = 32;
    localparam int TIMEOUT_W   = 24;
    localparam int CFG_W       = 48;
    localparam int POS_W       = 6;

    localparam logic [POS_W-1:0] FRAME_LEN = 6'd42;
    localparam logic [POS_W-1:0] LAST_POS  = 6'd41;

    localparam logic [15:0] ETHERTYPE_ARP = 16'h0806;
    localparam logic [15:0] HTYPE_ETH     = 16'h0001;
    localparam logic [15:0] PTYPE_IPV4    = 16'h0800;
    localparam logic [7:0]  HLEN_ETH      = 8'h06;
    localparam logic [7:0]  PLEN_IPV4     = 8'h04;
    localparam logic [15:0] OPER_REQUEST  = 16'h0001;
    localparam logic [15:0] OPER_REPLY    = 16'h0002;
    localparam logic [7:0]  BCAST_BYTE    = 8'hFF;

    localparam logic [MAC_W-1:0]     LOCAL_MAC_RST = 48'h0;
    localparam logic [IP_W-1:0]      SENDER_IP_RST = 32'h0A00020F;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST   = 24'd200000;

    typedef enum logic [1:0] {
        OP_RESOLVE = 2'd0,
        OP_RX_BYTE = 2'd1,
        OP_TICK    = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        KIND_TX       = 2'd0,
        KIND_RESOLVED = 2'd1,
        KIND_FAILED   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        CFG_LOCAL_MAC = 2'd0,
        CFG_SENDER_IP = 2'd1,
        CFG_TIMEOUT   = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic             frame_ok;
        logic [MAC_W-1:0] sender_mac;
    } rx_result_t;

    function automatic logic [TIMER_WIDTH-1:0] timer_load(logic [TIMEOUT_W-1:0] v);
        logic [31:0] ext;
        ext = 32'(v);
        return ext[TIMER_WIDTH-1:0];
    endfunction

endpackage

>>> rtl/arpres_rx_parse.sv
// Receive parser of the ARP resolver: checks reply frame bytes as they arrive.
// Depends on arpres_pkg.
module arpres_rx_parse (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic [7:0]                    rx_byte,
    input  logic                          rx_last,
    input  logic [arpres_pkg::IP_W-1:0]   sought_ip,
    output arpres_pkg::rx_result_t        res
);
    import arpres_pkg::*;

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic             match_reg;
    logic             match_next;
    logic [MAC_W-1:0] smac_reg;
    logic [MAC_W-1:0] smac_next;
    logic [POS_W-1:0] pos_inc;
    logic [POS_W-1:0] ip_k;
    logic [7:0]       ip_byte;
    logic [7:0]       exp_byte;
    logic             exp_check;
    logic             bad;

    always_comb
    begin
        exp_check = 1'b1;
        exp_byte  = 8'h00;
        case (pos_reg)
            6'd12: exp_byte = ETHERTYPE_ARP[15:8];
            6'd13: exp_byte = ETHERTYPE_ARP[7:0];
            6'd14: exp_byte = HTYPE_ETH[15:8];
            6'd15: exp_byte = HTYPE_ETH[7:0];
            6'd16: exp_byte = PTYPE_IPV4[15:8];
            6'd17: exp_byte = PTYPE_IPV4[7:0];
            6'd20: exp_byte = OPER_REPLY[15:8];
            6'd21: exp_byte = OPER_REPLY[7:0];
            default: exp_check = 1'b0;
        endcase
    end

    always_comb
    begin
        ip_k    = 6'd31 - pos_reg;
        ip_byte = 8'(sought_ip >> {ip_k[1:0], 3'b000});
        bad     = (exp_check && (exp_byte != rx_byte))
               || ((pos_reg >= 6'd28) && (pos_reg < 6'd32) && (ip_byte != rx_byte));
        match_next = match_reg && !bad;
        if ((pos_reg >= 6'd22) && (pos_reg < 6'd28))
        begin
            smac_next = {smac_reg[MAC_W-9:0], rx_byte};
        end
        else
        begin
            smac_next = smac_reg;
        end
        pos_inc = (pos_reg < FRAME_LEN) ? pos_reg + 6'd1 : pos_reg;
        pos_next = rx_last ? '0 : pos_inc;
        res.frame_ok   = rx_last && (pos_inc == FRAME_LEN) && match_next;
        res.sender_mac = smac_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            match_reg <= 1'b1;
            smac_reg  <= '0;
        end
        else if (step)
        begin
            pos_reg   <= pos_next;
            match_reg <= rx_last ? 1'b1 : match_next;
            smac_reg  <= smac_next;
        end
    end

endmodule

>>> rtl/arp_resolver_single_entry.sv
// Top level of the ARP resolver with a one-entry cache.
// Depends on arpres_pkg and arpres_rx_parse.
//
// Usage: items enter on the input channel (in_valid, in_stall) with an
// operation code: resolve a target IP, one received frame byte, or a tick.
// Results leave on the output channel (out_valid, out_stall) as transmit
// bytes of a request frame, resolved answers or failed answers.
// The user writes configuration (local MAC, own IP, timeout) through cfg_we,
// cfg_index and cfg_data only while idle; the block does not enforce this.
// An item passes an input register and then a result register; its first
// result is presented once the input register hands the item on, and the
// receiver takes it when out_stall is low. Ticks, received bytes and cache
// hits leave the input register as they pass, so one item can be accepted
// every cycle while out_stall is low and no request frame is being sent.
// A cache miss emits a 42-byte request frame, one byte per cycle from the
// frame generator unless stalled; another item can wait in the input register.
// When the receiver stalls, the result register holds its item and the
// input register fills, after which in_stall rises.
// Reset empties both registers, clears the cache and any pending request,
// and restores the configuration defaults.
module arp_resolver_single_entry (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        operation,
    input  logic [arpres_pkg::IP_W-1:0]       query_ip,
    input  logic [7:0]                        rx_byte,
    input  logic                              rx_last,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [1:0]                        kind,
    output logic [7:0]                        tx_byte,
    output logic                              tx_last,
    output logic [arpres_pkg::MAC_W-1:0]      mac,
    input  logic                              cfg_we,
    input  logic [1:0]                        cfg_index,
    input  logic [arpres_pkg::CFG_W-1:0]      cfg_data
);
    import arpres_pkg::*;

    function automatic logic [7:0] request_byte(logic [POS_W-1:0] i, logic [MAC_W-1:0] lmac,
                                                logic [IP_W-1:0] sip, logic [IP_W-1:0] tip);
        logic [POS_W-1:0] k_src;
        logic [POS_W-1:0] k_sha;
        logic [POS_W-1:0] k_spa;
        logic [POS_W-1:0] k_tpa;
        logic [7:0]       b;
        k_src = 6'd11 - i;
        k_sha = 6'd27 - i;
        k_spa = 6'd31 - i;
        k_tpa = 6'd41 - i;
        if (i < 6'd6)
        begin
            b = BCAST_BYTE;
        end
        else if (i < 6'd12)
        begin
            b = 8'(lmac >> {k_src[2:0], 3'b000});
        end
        else if (i < 6'd22)
        begin
            case (i)
                6'd12:   b = ETHERTYPE_ARP[15:8];
                6'd13:   b = ETHERTYPE_ARP[7:0];
                6'd14:   b = HTYPE_ETH[15:8];
                6'd15:   b = HTYPE_ETH[7:0];
                6'd16:   b = PTYPE_IPV4[15:8];
                6'd17:   b = PTYPE_IPV4[7:0];
                6'd18:   b = HLEN_ETH;
                6'd19:   b = PLEN_IPV4;
                6'd20:   b = OPER_REQUEST[15:8];
                default: b = OPER_REQUEST[7:0];
            endcase
        end
        else if (i < 6'd28)
        begin
            b = 8'(lmac >> {k_sha[2:0], 3'b000});
        end
        else if (i < 6'd32)
        begin
            b = 8'(sip >> {k_spa[1:0], 3'b000});
        end
        else if (i < 6'd38)
        begin
            b = 8'h00;
        end
        else
        begin
            b = 8'(tip >> {k_tpa[1:0], 3'b000});
        end
        return b;
    endfunction

    logic [MAC_W-1:0]       local_mac_reg;
    logic [IP_W-1:0]        sender_ip_reg;
    logic [TIMEOUT_W-1:0]   timeout_reg;

    logic                   s1_vld_reg;
    logic [1:0]             s1_op_reg;
    logic [IP_W-1:0]        s1_tip_reg;
    logic [7:0]             s1_byte_reg;
    logic                   s1_last_reg;

    logic                   entry_valid_reg;
    logic                   entry_valid_next;
    logic [IP_W-1:0]        entry_ip_reg;
    logic [IP_W-1:0]        entry_ip_next;
    logic [MAC_W-1:0]       entry_mac_reg;
    logic [MAC_W-1:0]       entry_mac_next;
    logic                   pending_reg;
    logic                   pending_next;
    logic [IP_W-1:0]        sought_ip_reg;
    logic [IP_W-1:0]        sought_ip_next;
    logic [TIMER_WIDTH-1:0] ticks_reg;
    logic [TIMER_WIDTH-1:0] ticks_next;

    logic                   gen_active_reg;
    logic                   gen_active_next;
    logic [POS_W-1:0]       gen_idx_reg;
    logic [POS_W-1:0]       gen_idx_next;
    logic [IP_W-1:0]        gen_tip_reg;
    logic [IP_W-1:0]        gen_tip_next;

    logic                   out_vld_reg;
    logic [1:0]             kind_reg;
    logic [7:0]             tx_byte_reg;
    logic                   tx_last_reg;
    logic [MAC_W-1:0]       mac_reg;

    logic                   out_free;
    logic                   s1_take;
    logic                   in_accept;
    logic                   rx_step;
    rx_result_t             rx_res;

    logic                   emit;
    logic [1:0]             emit_kind;
    logic [7:0]             emit_byte;
    logic                   emit_last;
    logic [MAC_W-1:0]       emit_mac;

    assign out_free  = !out_vld_reg || !out_stall;
    assign s1_take   = s1_vld_reg && out_free && !gen_active_reg;
    assign in_stall  = s1_vld_reg && !s1_take;
    assign in_accept = in_valid && !in_stall;

    assign out_valid = out_vld_reg;
    assign kind      = kind_reg;
    assign tx_byte   = tx_byte_reg;
    assign tx_last   = tx_last_reg;
    assign mac       = mac_reg;

    arpres_rx_parse u_rx_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (rx_step),
        .rx_byte   (s1_byte_reg),
        .rx_last   (s1_last_reg),
        .sought_ip (sought_ip_reg),
        .res       (rx_res)
    );

    always_comb
    begin
        entry_valid_next = entry_valid_reg;
        entry_ip_next    = entry_ip_reg;
        entry_mac_next   = entry_mac_reg;
        pending_next     = pending_reg;
        sought_ip_next   = sought_ip_reg;
        ticks_next       = ticks_reg;
        gen_active_next  = gen_active_reg;
        gen_idx_next     = gen_idx_reg;
        gen_tip_next     = gen_tip_reg;
        rx_step          = 1'b0;
        emit             = 1'b0;
        emit_kind        = KIND_TX;
        emit_byte        = 8'h00;
        emit_last        = 1'b0;
        emit_mac         = '0;

        if (out_free && gen_active_reg)
        begin
            emit      = 1'b1;
            emit_byte = request_byte(gen_idx_reg, local_mac_reg, sender_ip_reg, gen_tip_reg);
            emit_last = (gen_idx_reg == LAST_POS);
            if (gen_idx_reg == LAST_POS)
            begin
                gen_active_next = 1'b0;
            end
            else
            begin
                gen_idx_next = gen_idx_reg + 6'd1;
            end
        end
        else if (s1_take)
        begin
            case (s1_op_reg)
                OP_RESOLVE:
                begin
                    emit = 1'b1;
                    if (entry_valid_reg && (entry_ip_reg == s1_tip_reg))
                    begin
                        emit_kind = KIND_RESOLVED;
                        emit_mac  = entry_mac_reg;
                    end
                    else
                    begin
                        emit_byte       = request_byte('0, local_mac_reg, sender_ip_reg,
                                                       s1_tip_reg);
                        gen_active_next = 1'b1;
                        gen_idx_next    = 6'd1;
                        gen_tip_next    = s1_tip_reg;
                        pending_next    = 1'b1;
                        sought_ip_next  = s1_tip_reg;
                        ticks_next      = timer_load(timeout_reg);
                    end
                end
                OP_RX_BYTE:
                begin
                    rx_step = 1'b1;
                    if (rx_res.frame_ok && pending_reg)
                    begin
                        entry_valid_next = 1'b1;
                        entry_ip_next    = sought_ip_reg;
                        entry_mac_next   = rx_res.sender_mac;
                        pending_next     = 1'b0;
                        emit             = 1'b1;
                        emit_kind        = KIND_RESOLVED;
                        emit_mac         = rx_res.sender_mac;
                    end
                end
                OP_TICK:
                begin
                    if (pending_reg)
                    begin
                        if (ticks_reg <= TIMER_WIDTH'(1))
                        begin
                            ticks_next   = '0;
                            pending_next = 1'b0;
                            emit         = 1'b1;
                            emit_kind    = KIND_FAILED;
                        end
                        else
                        begin
                            ticks_next = ticks_reg - TIMER_WIDTH'(1);
                        end
                    end
                end
                default:
                begin
                    emit = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_mac_reg   <= LOCAL_MAC_RST;
            sender_ip_reg   <= SENDER_IP_RST;
            timeout_reg     <= TIMEOUT_RST;
            s1_vld_reg      <= 1'b0;
            entry_valid_reg <= 1'b0;
            pending_reg     <= 1'b0;
            sought_ip_reg   <= '0;
            gen_active_reg  <= 1'b0;
            out_vld_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_LOCAL_MAC: local_mac_reg <= cfg_data;
                    CFG_SENDER_IP: sender_ip_reg <= cfg_data[IP_W-1:0];
                    CFG_TIMEOUT:   timeout_reg   <= cfg_data[TIMEOUT_W-1:0];
                    default:       timeout_reg   <= timeout_reg;
                endcase
            end
            if (in_accept)
            begin
                s1_vld_reg <= 1'b1;
            end
            else if (s1_take)
            begin
                s1_vld_reg <= 1'b0;
            end
            entry_valid_reg <= entry_valid_next;
            pending_reg     <= pending_next;
            sought_ip_reg   <= sought_ip_next;
            gen_active_reg  <= gen_active_next;
            if (out_free)
            begin
                out_vld_reg <= emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_op_reg   <= operation;
            s1_tip_reg  <= query_ip;
            s1_byte_reg <= rx_byte;
            s1_last_reg <= rx_last;
        end
        entry_ip_reg  <= entry_ip_next;
        entry_mac_reg <= entry_mac_next;
        ticks_reg     <= ticks_next;
        gen_idx_reg   <= gen_idx_next;
        gen_tip_reg   <= gen_tip_next;
        if (out_free && emit)
        begin
            kind_reg    <= emit_kind;
            tx_byte_reg <= emit_byte;
            tx_last_reg <= emit_last;
            mac_reg     <= emit_mac;
        end
    end

endmodule

>>> rtl/arpres_port_check.sv
// Port checker for the ARP resolver, attached to the top level by bind.
// Depends on arpres_pkg and arp_resolver_single_entry_defines.svh.
`include "arp_resolver_single_entry_defines.svh"

module arpres_port_check (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic [1:0]                        kind,
    input  logic [7:0]                        tx_byte,
    input  logic                              tx_last,
    input  logic [arpres_pkg::MAC_W-1:0]      mac
);
    import arpres_pkg::*;

    `ARPRES_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(kind) && $stable(tx_byte) && $stable(tx_last) && $stable(mac),
        "A stalled item changed or vanished.")

    `ARPRES_ASSERT_SAME(a_last_is_tx, out_valid && tx_last, kind == KIND_TX,
        "The frame end mark was set on an answer item.")

    `ARPRES_ASSERT_SAME(a_answer_clean, out_valid && (kind != KIND_TX),
        (tx_byte == 8'h00) && !tx_last && ((kind == KIND_RESOLVED) || (mac == '0)),
        "An answer item carries stray frame or address bits.")

    `ARPRES_ASSERT_NEXT(a_frame_gapless,
        out_valid && !out_stall && (kind == KIND_TX) && !tx_last,
        out_valid && (kind == KIND_TX) && (mac == '0),
        "A request frame was interrupted before its last byte.")

endmodule

bind arp_resolver_single_entry arpres_port_check u_port_check (.*);
